@@ rtl/five_point_derivative_assert.svh @@
// Assertion helpers shared by the derivative block.
`ifndef FIVE_POINT_DERIVATIVE_ASSERT_SVH
`define FIVE_POINT_DERIVATIVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fpd_pkg.sv @@
`timescale 1ns / 1ps

package fpd_pkg;

   localparam int SCALE_W = 32;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FIVE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_THREE = 1'b1;

   // Samples seen in the current run, saturating.
   localparam int RUN_W = 3;
   localparam logic [RUN_W-1:0] RUN_ZERO  = 3'd0;
   localparam logic [RUN_W-1:0] RUN_ONE   = 3'd1;
   localparam logic [RUN_W-1:0] RUN_TWO   = 3'd2;
   localparam logic [RUN_W-1:0] RUN_THREE = 3'd3;
   localparam logic [RUN_W-1:0] RUN_MAX   = 3'd7;

   // Extra bits a five-point stencil sum needs over one sample.
   localparam int STENCIL_GROW = 5;

   // Up to three results per sample.
   localparam int OP_SLOTS = 3;
   localparam int OP_CNT_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam int LANES   = 2;
   localparam int LANE_RE = 0;
   localparam int LANE_IM = 1;

   typedef struct packed {
      logic use_three;
      logic last;
   } op_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

@@ rtl/fpd_req_if.sv @@
`timescale 1ns / 1ps

interface fpd_req_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_re;
   logic signed [SAMPLE_WIDTH-1:0] sample_im;
   logic                           last_in;

   modport source (output valid, sample_re, sample_im, last_in, input ready);
   modport sink   (input valid, sample_re, sample_im, last_in, output ready);
endinterface

@@ rtl/fpd_rsp_if.sv @@
`timescale 1ns / 1ps

interface fpd_rsp_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] deriv_re;
   logic signed [SAMPLE_WIDTH-1:0] deriv_im;
   logic                           last_out;

   modport source (output valid, deriv_re, deriv_im, last_out, input ready);
   modport sink   (input valid, deriv_re, deriv_im, last_out, output ready);
endinterface

@@ rtl/five_point_derivative.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Payload                               Handshake
// req_ch    in         sample_re, sample_im, last_in         valid / ready
// rsp_ch    out        deriv_re, deriv_im, last_out          valid / ready
// csr_*     in         csr_index, csr_wdata                  csr_we, no wait
//
// One sample per cycle while the queue has room and each sample yields at
// most one result; a last sample yields up to three results and holds
// req_ch.ready low while its op slots drain into the queue, one slot per
// cycle while the queue is not full. A result passes from its transaction
// through the front op slots, the queue and then the five back pipeline
// registers (the first loads as the queue pops). Reset (synchronous) empties
// the slots, the queue and the pipeline, clears the run count and sets both
// scales to 1.0. A stalled rsp_ch freezes the back pipeline; the four-entry
// queue absorbs the front until it fills, then req_ch.ready drops.

module five_point_derivative #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   fpd_req_if.sink                            req_ch,
   fpd_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [fpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fpd_pkg::SCALE_W-1:0]        csr_wdata
);

   localparam int SUM_W = SAMPLE_WIDTH + fpd_pkg::STENCIL_GROW;

   // Scale registers, Q16.16 unsigned.
   logic [fpd_pkg::SCALE_W-1:0] scale_five_ff;
   logic [fpd_pkg::SCALE_W-1:0] scale_three_ff;

   // Front to queue.
   logic                    push;
   fpd_pkg::op_ctrl_type    push_ctrl;
   logic signed [SUM_W-1:0] push_re, push_im;

   // Queue to back.
   logic                    pop;
   fpd_pkg::op_ctrl_type    head_ctrl;
   logic signed [SUM_W-1:0] head_re, head_im;
   fpd_pkg::queue_stat_type q_stat;

   logic                           front_ready;
   logic                           back_valid;
   logic signed [SAMPLE_WIDTH-1:0] back_re, back_im;
   logic                           back_last;

   // Take register writes; indexes past the list drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_five_ff  <= fpd_pkg::SCALE_RESET;
         scale_three_ff <= fpd_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fpd_pkg::CSR_SCALE_FIVE: begin
               scale_five_ff <= csr_wdata;
            end
            fpd_pkg::CSR_SCALE_THREE: begin
               scale_three_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Front: hold history and run count, turn each transaction into ops.
   fpd_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (front_ready),
      .sample_re (SAMPLE_WIDTH'(req_ch.sample_re)),
      .sample_im (SAMPLE_WIDTH'(req_ch.sample_im)),
      .last_in   (req_ch.last_in),
      .q_stat    (q_stat),
      .q_push    (push),
      .q_ctrl    (push_ctrl),
      .q_sum_re  (push_re),
      .q_sum_im  (push_im)
   );

   // Queue: decouple front from back.
   fpd_queue #(
      .SUM_W (SUM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .ctrl_in    (push_ctrl),
      .sum_re_in  (push_re),
      .sum_im_in  (push_im),
      .pop        (pop),
      .ctrl_out   (head_ctrl),
      .sum_re_out (head_re),
      .sum_im_out (head_im),
      .stat       (q_stat)
   );

   // Back: scale, floor-shift and saturate each op.
   fpd_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_stat      (q_stat),
      .q_pop       (pop),
      .q_ctrl      (head_ctrl),
      .q_sum_re    (head_re),
      .q_sum_im    (head_im),
      .scale_five  (scale_five_ff),
      .scale_three (scale_three_ff),
      .rsp_valid   (back_valid),
      .rsp_ready   (rsp_ch.ready),
      .deriv_re    (back_re),
      .deriv_im    (back_im),
      .last_out    (back_last)
   );

   assign req_ch.ready    = front_ready;
   assign rsp_ch.valid    = back_valid;
   assign rsp_ch.deriv_re = back_re;
   assign rsp_ch.deriv_im = back_im;
   assign rsp_ch.last_out = back_last;

endmodule

@@ rtl/fpd_front.sv @@
`timescale 1ns / 1ps

`include "five_point_derivative_assert.svh"

module fpd_front #(
   parameter int SAMPLE_WIDTH = 32,
   localparam int SUM_W = SAMPLE_WIDTH + fpd_pkg::STENCIL_GROW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
   input  logic                           last_in,
   input  fpd_pkg::queue_stat_type        q_stat,
   output logic                           q_push,
   output fpd_pkg::op_ctrl_type           q_ctrl,
   output logic signed [SUM_W-1:0]        q_sum_re,
   output logic signed [SUM_W-1:0]        q_sum_im
);

   logic signed [SAMPLE_WIDTH-1:0] hist_re_ff [4];
   logic signed [SAMPLE_WIDTH-1:0] hist_im_ff [4];
   logic [fpd_pkg::RUN_W-1:0]      run_ff;

   fpd_pkg::op_ctrl_type      op_ctrl_ff [fpd_pkg::OP_SLOTS];
   logic signed [SUM_W-1:0]   op_re_ff   [fpd_pkg::OP_SLOTS];
   logic signed [SUM_W-1:0]   op_im_ff   [fpd_pkg::OP_SLOTS];
   logic [fpd_pkg::OP_CNT_W-1:0] cnt_ff;

   fpd_pkg::op_ctrl_type      op_ctrl_in [fpd_pkg::OP_SLOTS];
   logic signed [SUM_W-1:0]   op_re_in   [fpd_pkg::OP_SLOTS];
   logic signed [SUM_W-1:0]   op_im_in   [fpd_pkg::OP_SLOTS];
   logic [fpd_pkg::OP_CNT_W-1:0] cnt_in;

   logic signed [SUM_W-1:0] five_re, five_im, mid_re, mid_im, end_re, end_im;
   fpd_pkg::op_ctrl_type    a_ctrl;
   logic signed [SUM_W-1:0] a_re, a_im;
   logic                    accept;

   assign q_push    = (cnt_ff != '0) && !q_stat.full;
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == fpd_pkg::OP_CNT_W'(1)) && q_push);
   assign accept    = req_valid && req_ready;

   assign q_ctrl   = op_ctrl_ff[0];
   assign q_sum_re = op_re_ff[0];
   assign q_sum_im = op_im_ff[0];

   // Stencil sums over newest-first history.
   always_comb begin
      five_re = SUM_W'(hist_re_ff[3]) - (SUM_W'(hist_re_ff[2]) <<< 3)
              + (SUM_W'(hist_re_ff[0]) <<< 3) - SUM_W'(sample_re);
      five_im = SUM_W'(hist_im_ff[3]) - (SUM_W'(hist_im_ff[2]) <<< 3)
              + (SUM_W'(hist_im_ff[0]) <<< 3) - SUM_W'(sample_im);
      mid_re  = SUM_W'(hist_re_ff[0]) - SUM_W'(hist_re_ff[2]);
      mid_im  = SUM_W'(hist_im_ff[0]) - SUM_W'(hist_im_ff[2]);
      end_re  = SUM_W'(sample_re) - SUM_W'(hist_re_ff[1]);
      end_im  = SUM_W'(sample_im) - SUM_W'(hist_im_ff[1]);
   end

   // Classify the sample into its results.
   always_comb begin
      a_ctrl = '{use_three: 1'b0, last: 1'b0};
      a_re   = five_re;
      a_im   = five_im;
      if (run_ff == fpd_pkg::RUN_TWO) begin
         a_re = '0;
         a_im = '0;
      end else if (run_ff == fpd_pkg::RUN_THREE) begin
         a_ctrl.use_three = 1'b1;
         a_re             = mid_re;
         a_im             = mid_im;
      end

      cnt_in = '0;
      for (int i = 0; i < fpd_pkg::OP_SLOTS; i++) begin
         op_ctrl_in[i] = '{use_three: 1'b0, last: 1'b0};
         op_re_in[i]   = '0;
         op_im_in[i]   = '0;
      end

      if (!last_in) begin
         if (!(run_ff inside {fpd_pkg::RUN_ZERO, fpd_pkg::RUN_ONE})) begin
            cnt_in        = fpd_pkg::OP_CNT_W'(1);
            op_ctrl_in[0] = a_ctrl;
            op_re_in[0]   = a_re;
            op_im_in[0]   = a_im;
         end
      end else if (run_ff == fpd_pkg::RUN_ZERO) begin
         cnt_in             = fpd_pkg::OP_CNT_W'(1);
         op_ctrl_in[0].last = 1'b1;
      end else if (run_ff == fpd_pkg::RUN_ONE) begin
         cnt_in             = fpd_pkg::OP_CNT_W'(2);
         op_ctrl_in[1].last = 1'b1;
      end else begin
         cnt_in                  = fpd_pkg::OP_CNT_W'(3);
         op_ctrl_in[0]           = a_ctrl;
         op_re_in[0]             = a_re;
         op_im_in[0]             = a_im;
         op_ctrl_in[1].use_three = 1'b1;
         op_re_in[1]             = end_re;
         op_im_in[1]             = end_im;
         op_ctrl_in[2].last      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         run_ff <= fpd_pkg::RUN_ZERO;
      end else begin
         if (accept) begin
            cnt_ff <= cnt_in;
         end else if (q_push) begin
            cnt_ff <= cnt_ff - fpd_pkg::OP_CNT_W'(1);
         end
         if (accept) begin
            if (last_in) begin
               run_ff <= fpd_pkg::RUN_ZERO;
            end else if (run_ff != fpd_pkg::RUN_MAX) begin
               run_ff <= run_ff + fpd_pkg::RUN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < fpd_pkg::OP_SLOTS; i++) begin
            op_ctrl_ff[i] <= op_ctrl_in[i];
            op_re_ff[i]   <= op_re_in[i];
            op_im_ff[i]   <= op_im_in[i];
         end
      end else if (q_push) begin
         for (int i = 0; i < fpd_pkg::OP_SLOTS - 1; i++) begin
            op_ctrl_ff[i] <= op_ctrl_ff[i+1];
            op_re_ff[i]   <= op_re_ff[i+1];
            op_im_ff[i]   <= op_im_ff[i+1];
         end
      end
      if (accept && !last_in) begin
         for (int i = 3; i > 0; i--) begin
            hist_re_ff[i] <= hist_re_ff[i-1];
            hist_im_ff[i] <= hist_im_ff[i-1];
         end
         hist_re_ff[0] <= sample_re;
         hist_im_ff[0] <= sample_im;
      end
   end

   `FPD_ASSERT_NOW(a_accept_slots_free, clock, reset, accept, cnt_ff <= fpd_pkg::OP_CNT_W'(1), "sample taken while results still pending")
   `FPD_ASSERT_NEXT(a_last_clears_run, clock, reset, accept && last_in, run_ff == fpd_pkg::RUN_ZERO, "run count not cleared after last sample")
   `FPD_ASSERT_NEXT(a_last_full_flush, clock, reset, accept && last_in && run_ff >= fpd_pkg::RUN_TWO, cnt_ff == fpd_pkg::OP_CNT_W'(3), "last sample did not queue three results")

endmodule

@@ rtl/fpd_queue.sv @@
`timescale 1ns / 1ps

`include "five_point_derivative_assert.svh"

module fpd_queue #(
   parameter int SUM_W = 37
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fpd_pkg::op_ctrl_type    ctrl_in,
   input  logic signed [SUM_W-1:0] sum_re_in,
   input  logic signed [SUM_W-1:0] sum_im_in,
   input  logic                    pop,
   output fpd_pkg::op_ctrl_type    ctrl_out,
   output logic signed [SUM_W-1:0] sum_re_out,
   output logic signed [SUM_W-1:0] sum_im_out,
   output fpd_pkg::queue_stat_type stat
);

   fpd_pkg::op_ctrl_type    ctrl_ff [fpd_pkg::QUEUE_DEPTH];
   logic signed [SUM_W-1:0] re_ff   [fpd_pkg::QUEUE_DEPTH];
   logic signed [SUM_W-1:0] im_ff   [fpd_pkg::QUEUE_DEPTH];

   logic [fpd_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fpd_pkg::QCNT_W-1:0] count_ff;

   assign stat.full  = (count_ff == fpd_pkg::QCNT_W'(fpd_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   assign ctrl_out   = ctrl_ff[rd_ptr_ff];
   assign sum_re_out = re_ff[rd_ptr_ff];
   assign sum_im_out = im_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + fpd_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + fpd_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + fpd_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - fpd_pkg::QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ptr_ff] <= ctrl_in;
         re_ff[wr_ptr_ff]   <= sum_re_in;
         im_ff[wr_ptr_ff]   <= sum_im_in;
      end
   end

   `FPD_ASSERT_NOW(a_no_overflow, clock, reset, push, !stat.full, "queue push while full")
   `FPD_ASSERT_NOW(a_no_underflow, clock, reset, pop, !stat.empty, "queue pop while empty")
   `FPD_ASSERT_NEXT(a_idle_holds, clock, reset, !push && !pop, $stable(count_ff), "queue count moved without push or pop")

endmodule

@@ rtl/fpd_back.sv @@
`timescale 1ns / 1ps

module fpd_back #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   localparam int SUM_W = SAMPLE_WIDTH + fpd_pkg::STENCIL_GROW
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fpd_pkg::queue_stat_type           q_stat,
   output logic                              q_pop,
   input  fpd_pkg::op_ctrl_type              q_ctrl,
   input  logic signed [SUM_W-1:0]           q_sum_re,
   input  logic signed [SUM_W-1:0]           q_sum_im,
   input  logic [fpd_pkg::SCALE_W-1:0]       scale_five,
   input  logic [fpd_pkg::SCALE_W-1:0]       scale_three,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]    deriv_re,
   output logic signed [SAMPLE_WIDTH-1:0]    deriv_im,
   output logic                              last_out
);

   localparam int SW     = fpd_pkg::SCALE_W;
   localparam int LO_W   = (SUM_W + 1) / 2;
   localparam int HI_W   = SUM_W - LO_W;
   localparam int PL_W   = LO_W + SW;
   localparam int PH_W   = HI_W + SW;
   localparam int PROD_W = SUM_W + SW;
   localparam int Q_W    = PROD_W - FRAC_BITS;
   localparam int NL     = fpd_pkg::LANES;

   localparam logic [Q_W:0] LIM_NEG = (Q_W+1)'(1) << (SAMPLE_WIDTH - 1);
   localparam logic [Q_W:0] LIM_POS = LIM_NEG - (Q_W+1)'(1);

   logic adv;

   logic v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic last1_ff, last2_ff, last3_ff, last4_ff, lasto_ff;

   logic                    neg1_ff [NL];
   logic [SUM_W-1:0]        mag1_ff [NL];
   logic [SW-1:0]           scale1_ff;
   logic                    neg2_ff [NL];
   logic [PL_W-1:0]         pl2_ff  [NL];
   logic [PH_W-1:0]         ph2_ff  [NL];
   logic                    neg3_ff [NL];
   logic [PROD_W-1:0]       prod3_ff [NL];
   logic                    neg4_ff [NL];
   logic [Q_W:0]            q4_ff   [NL];
   logic signed [SAMPLE_WIDTH-1:0] res_ff [NL];

   logic signed [SUM_W-1:0] sum_in [NL];
   logic                    neg_in [NL];
   logic [SUM_W-1:0]        mag_in [NL];
   logic [Q_W:0]            lim    [NL];
   logic [SAMPLE_WIDTH-1:0] sat    [NL];

   // Whole pipe moves together; the output register gates it.
   assign adv   = !vo_ff || rsp_ready;
   assign q_pop = adv && !q_stat.empty;

   assign rsp_valid = vo_ff;
   assign deriv_re  = res_ff[fpd_pkg::LANE_RE];
   assign deriv_im  = res_ff[fpd_pkg::LANE_IM];
   assign last_out  = lasto_ff;

   always_comb begin
      sum_in[fpd_pkg::LANE_RE] = q_sum_re;
      sum_in[fpd_pkg::LANE_IM] = q_sum_im;
      for (int l = 0; l < NL; l++) begin
         neg_in[l] = sum_in[l][SUM_W-1];
         mag_in[l] = neg_in[l] ? (-sum_in[l]) : sum_in[l];
         lim[l]    = neg4_ff[l] ? LIM_NEG : LIM_POS;
         sat[l]    = (q4_ff[l] > lim[l]) ? lim[l][SAMPLE_WIDTH-1:0]
                                         : q4_ff[l][SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last1_ff  <= q_ctrl.last;
         last2_ff  <= last1_ff;
         last3_ff  <= last2_ff;
         last4_ff  <= last3_ff;
         lasto_ff  <= last4_ff;
         scale1_ff <= q_ctrl.use_three ? scale_three : scale_five;
         for (int l = 0; l < NL; l++) begin
            // magnitude and sign
            neg1_ff[l]  <= neg_in[l];
            mag1_ff[l]  <= mag_in[l];
            // split product
            neg2_ff[l]  <= neg1_ff[l];
            pl2_ff[l]   <= PL_W'(mag1_ff[l][LO_W-1:0]) * PL_W'(scale1_ff);
            ph2_ff[l]   <= PH_W'(mag1_ff[l][SUM_W-1:LO_W]) * PH_W'(scale1_ff);
            // combine partials
            neg3_ff[l]  <= neg2_ff[l];
            prod3_ff[l] <= PROD_W'(pl2_ff[l]) + (PROD_W'(ph2_ff[l]) << LO_W);
            // floor shift: round magnitude up when negative with lost bits
            neg4_ff[l]  <= neg3_ff[l];
            q4_ff[l]    <= (Q_W+1)'(prod3_ff[l][PROD_W-1:FRAC_BITS])
                         + (Q_W+1)'(neg3_ff[l] && (|prod3_ff[l][FRAC_BITS-1:0]));
            // saturate and restore sign
            res_ff[l]   <= neg4_ff[l] ? -sat[l] : sat[l];
         end
      end
   end

endmodule
